// ----- rtl/sgr_pkg.sv -----
// Shared types, the 5x7 font ROM and the vertical glyph scaler of the glyph rasterizer.
// Has no dependencies; the controller, the datapath and the top level import it.
`default_nettype none
package sgr_pkg;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic iter_done;
      logic out_free;
   } status_type;

   // Five glyph columns, one byte each, column 0 in the lowest byte; bit n is glyph row n.
   function automatic logic [39:0] font_rom(input logic [7:0] code);
      logic [39:0] g;
      unique case (code)
         8'h30: g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         8'h31: g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         8'h32: g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         8'h33: g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         8'h34: g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         8'h35: g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         8'h36: g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         8'h37: g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         8'h3A: g = {8'h00, 8'h22, 8'h00, 8'h22, 8'h00};
         8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         8'h42: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h43: g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h44: g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
         8'h45: g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
         8'h46: g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
         8'h47: g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
         8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         8'h4C: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
         8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         8'h4E: g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
         8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h50: g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
         8'h52: g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
         8'h53: g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
         8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         8'h55: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h7F};
         8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h40, 8'h7F};
         8'h57: g = {8'h7F, 8'h20, 8'h10, 8'h20, 8'h7F};
         8'h61: g = {8'h78, 8'h54, 8'h54, 8'h54, 8'h20};
         8'h62: g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
         8'h63: g = {8'h20, 8'h44, 8'h44, 8'h44, 8'h38};
         8'h64: g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
         8'h65: g = {8'h18, 8'h54, 8'h54, 8'h54, 8'h38};
         8'h67: g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
         8'h68: g = {8'h78, 8'h04, 8'h04, 8'h08, 8'h7F};
         8'h69: g = {8'h00, 8'h40, 8'h7D, 8'h44, 8'h00};
         8'h6B: g = {8'h40, 8'h44, 8'h28, 8'h10, 8'h7F};
         8'h6C: g = {8'h00, 8'h40, 8'h7F, 8'h41, 8'h00};
         8'h6D: g = {8'h78, 8'h04, 8'h18, 8'h04, 8'h7C};
         8'h6E: g = {8'h78, 8'h04, 8'h04, 8'h08, 8'h7C};
         8'h6F: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
         8'h72: g = {8'h08, 8'h04, 8'h04, 8'h18, 8'h7C};
         8'h73: g = {8'h24, 8'h54, 8'h54, 8'h54, 8'h48};
         8'h74: g = {8'h20, 8'h40, 8'h44, 8'h3F, 8'h04};
         8'h75: g = {8'h7C, 8'h20, 8'h40, 8'h40, 8'h3C};
         8'h77: g = {8'h7C, 8'h10, 8'h08, 8'h10, 8'h7C};
         8'h2D: g = {8'h00, 8'h08, 8'h08, 8'h08, 8'h00};
         8'h25: g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
         8'h2F: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
         8'h2E: g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         default: g = '0;
      endcase
      return g;
   endfunction

   // Repeats each of the seven glyph rows mag times downwards; a mag of 0 or 1 copies each row once.
   function automatic logic [23:0] scale_col(input logic [6:0] bits, input logic [1:0] mag);
      logic [23:0] s;
      s = '0;
      for (int r = 0; r < 7; r++) begin
         unique case (mag)
            2'd2: begin
               s[2*r]   = bits[r];
               s[2*r+1] = bits[r];
            end
            2'd3: begin
               s[3*r]   = bits[r];
               s[3*r+1] = bits[r];
               s[3*r+2] = bits[r];
            end
            default: s[r] = bits[r];
         endcase
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sgr_ctrl.sv -----
// Sequencing state machine of the glyph rasterizer.
// Depends on sgr_pkg for the command and status structures.
`default_nettype none
module sgr_ctrl import sgr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  var  status_type status,
   output cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      cmd.flush = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid && status.go) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = status.out_free;
            if (status.out_free && status.iter_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.flush = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sgr_datapath.sv -----
// Datapath of the glyph rasterizer: cursor and halt state, glyph walk counters,
// one-deep pending result for end-of-character marking and the output register. Uses sgr_pkg.
`default_nettype none
module sgr_datapath import sgr_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] char_code,
   input  wire logic [6:0] start_col,
   input  wire logic [2:0] start_page,
   input  wire logic [1:0] scale,
   input  wire logic       first_of_string,
   input  var  cmd_type    cmd,
   output status_type      status,
   input  wire logic       rsp_tready,
   output logic            rsp_tvalid,
   output logic [9:0]      byte_addr,
   output logic [7:0]      set_mask,
   output logic            last
);

   localparam logic [8:0] COL_LIMIT  = 9'(COLUMNS);
   localparam logic [5:0] PAGE_LIMIT = 6'(PAGES);
   localparam logic [1:0] K_LAST     = 2'd2;
   localparam logic [2:0] J_LAST     = 3'd4;

   logic [7:0]  cursor_ff;
   logic        halted_ff;
   logic [39:0] glyph_ff;
   logic [2:0]  page_ff;
   logic [1:0]  mag_ff;
   logic [8:0]  x_ff;
   logic [2:0]  j_ff;
   logic [1:0]  u_ff;
   logic [1:0]  k_ff;
   logic        pend_v_ff;
   logic [9:0]  pend_addr_ff;
   logic [7:0]  pend_mask_ff;
   logic        rsp_valid_ff;
   logic [9:0]  rsp_addr_ff;
   logic [7:0]  rsp_mask_ff;
   logic        rsp_last_ff;

   logic [7:0]  cur;
   logic        hlt;
   logic [3:0]  five_mag;
   logic [4:0]  six_mag;
   logic [8:0]  limit;
   logic [8:0]  adv;
   logic        blocked;
   logic        go;
   logic [6:0]  glyph_col;
   logic [23:0] scaled;
   logic [7:0]  mask;
   logic [4:0]  q;
   logic [15:0] addr_sum;
   logic        cand_v;
   logic        u_last;

   always_comb begin
      cur      = first_of_string ? {1'b0, start_col} : cursor_ff;
      hlt      = first_of_string ? 1'b0 : halted_ff;
      five_mag = 4'(scale) * 4'd5;
      six_mag  = 5'(scale) * 5'd6;
      limit    = COL_LIMIT - {5'b0, five_mag};
      blocked  = hlt || ({1'b0, cur} >= limit);
      go       = !blocked && (scale != 2'd0);
      adv      = {1'b0, cur} + {4'b0, six_mag};
   end

   always_comb begin
      glyph_col = glyph_ff[{j_ff, 3'b000} +: 7];
      scaled    = scale_col(glyph_col, mag_ff);
      mask      = scaled[{k_ff, 3'b000} +: 8];
      q         = {2'b0, page_ff} + {3'b0, k_ff};
      addr_sum  = 16'(q) * 16'(COLUMNS) + 16'(x_ff);
      cand_v    = (mask != 8'd0) && ({1'b0, q} < PAGE_LIMIT) && (x_ff < COL_LIMIT);
      u_last    = (u_ff == mag_ff - 2'd1);
   end

   assign status.go        = go;
   assign status.iter_done = (k_ff == K_LAST) && u_last && (j_ff == J_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         halted_ff <= 1'b0;
      end else if (cmd.load) begin
         halted_ff <= blocked;
         if (go) begin
            cursor_ff <= adv[8] ? 8'hFF : adv[7:0];
         end else begin
            cursor_ff <= cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         glyph_ff <= font_rom(char_code);
         page_ff  <= start_page;
         mag_ff   <= scale;
         x_ff     <= {1'b0, cur};
         j_ff     <= '0;
         u_ff     <= '0;
         k_ff     <= '0;
      end else if (cmd.step) begin
         if (k_ff == K_LAST) begin
            k_ff <= '0;
            x_ff <= x_ff + 9'd1;
            if (u_last) begin
               u_ff <= '0;
               j_ff <= j_ff + 3'd1;
            end else begin
               u_ff <= u_ff + 2'd1;
            end
         end else begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
      end else if (cmd.step && cand_v) begin
         pend_v_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && cand_v) begin
         pend_addr_ff <= addr_sum[9:0];
         pend_mask_ff <= mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.step && cand_v && pend_v_ff) || (cmd.flush && pend_v_ff)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.step && cand_v && pend_v_ff) || (cmd.flush && pend_v_ff)) begin
         rsp_addr_ff <= pend_addr_ff;
         rsp_mask_ff <= pend_mask_ff;
         rsp_last_ff <= cmd.flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign byte_addr  = rsp_addr_ff;
   assign set_mask   = rsp_mask_ff;
   assign last       = rsp_last_ff;

endmodule
`default_nettype wire

// ----- rtl/scaled_glyph_rasterizer_unit.sv -----
// Top level of the scaled 5x7 glyph rasterizer: one byte write per cycle at best.
// A character that is walked, blank glyphs included, passes through the transfer, five glyph
// columns times scale with three page slots each and one flush step; a halted or zero-scale one
// only through the transfer. Each byte write waits in the pending register, then moves to the
// output register; the last one of a character leaves with the flush.
// Synchronous reset clears the cursor, the halt flag, the sequencer and both valid flags.
`default_nettype none
module scaled_glyph_rasterizer_unit import sgr_pkg::*; #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // char_code[7:0], start_col[14:8], start_page[17:15], scale[19:18], zero fill[23:20]
   input  wire logic [23:0] req_tdata,
   // first_of_string[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // byte_addr[9:0], set_mask[17:10], zero fill[23:18]
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast
);

   cmd_type    cmd;
   status_type status;
   logic [9:0] byte_addr;
   logic [7:0] set_mask;

   sgr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sgr_datapath #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .char_code       (req_tdata[7:0]),
      .start_col       (req_tdata[14:8]),
      .start_page      (req_tdata[17:15]),
      .scale           (req_tdata[19:18]),
      .first_of_string (req_tuser),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .byte_addr       (byte_addr),
      .set_mask        (set_mask),
      .last            (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, set_mask, byte_addr};

   assert property (@(posedge clock) disable iff (reset) cmd.step |-> status.out_free)
      else $error("walk advanced while the output register was blocked");

   assert property (@(posedge clock) disable iff (reset) cmd.flush |=> req_tready)
      else $error("sequencer did not return to idle after the flush");

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !status.go) |=> req_tready)
      else $error("a character that draws nothing left the block busy");

endmodule
`default_nettype wire
